// ----- design/csi_pp_pkg.sv -----
// ============================================================================
// CSI parameter parser package
// Shared result word layout, scan phases and byte codes for the parser.
// ============================================================================
`default_nettype none

package csi_pp_pkg;

    // Scan phase of the parser
    typedef enum logic [2:0] {
        PH_START,
        PH_LEAD,
        PH_SIGN,
        PH_DIGIT,
        PH_COLON,
        PH_WAIT,
        PH_SKIP
    } phase_t;

    // Kinds of result word
    localparam logic [1:0] KIND_ARG     = 2'd0;
    localparam logic [1:0] KIND_SUB     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Byte codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    // One result word
    typedef struct packed {
        logic [1:0]  item_kind;
        logic [3:0]  arg_slot;
        logic [1:0]  sub_slot;
        logic [31:0] number_value;
        logic        private_mark;
        logic [7:0]  final_char;
        logic [7:0]  second_char;
        logic [4:0]  arg_total;
        logic        run_end;
    } result_t;

endpackage

`default_nettype wire

// ----- design/csi_parameter_parser_unit.sv -----
// ============================================================================
// CSI parameter parser
// Parses the parameter bytes of a CSI escape body into argument values,
// colon sub-argument values and an end-of-scan summary word.
// ============================================================================
// Takes one body byte per cycle on the slave stream while the queue has room
// (tlast marks the body's final byte) and reports each value as soon as its
// field ends, followed by a summary word with the stopping byte, the byte
// after it and the argument count. A byte's result words enter a four-word
// result queue the cycle after the byte is taken and leave at one word per
// cycle while m_tready is high; a byte may cause two words, so a byte stream
// that keeps producing two words is held back by the output side. The slave
// side is ready while at least two queue entries are free.
`default_nettype none

module csi_parameter_parser_unit #(
    parameter int MAX_ARGS    = 16,
    parameter int MAX_SUBARGS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // end_of_body
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // arg_slot, sub_slot, number_value, private_mark, final_char,
    // second_char, arg_total, zero fill
    output logic [63:0]      m_tdata,
    output logic [1:0]       m_tuser,   // item_kind
    output logic             m_tlast    // run_end
);
    import csi_pp_pkg::*;

    logic       take;
    logic [1:0] res_count;
    result_t    res_first;
    result_t    res_second;
    result_t    head;
    logic       room_two;

    assign take = s_tvalid && s_tready;

    csi_pp_core #(
        .MAX_ARGS    (MAX_ARGS),
        .MAX_SUBARGS (MAX_SUBARGS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .data_byte   (s_tdata),
        .end_of_body (s_tlast),
        .res_count   (res_count),
        .res_first   (res_first),
        .res_second  (res_second)
    );

    csi_pp_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_count  (res_count),
        .push_first  (res_first),
        .push_second (res_second),
        .pop         (m_tready),
        .head        (head),
        .not_empty   (m_tvalid),
        .room_two    (room_two)
    );

    assign s_tready = room_two;

    // Pack the head word onto the master stream
    assign m_tdata = {4'd0, head.arg_total, head.second_char, head.final_char,
                      head.private_mark, head.number_value, head.sub_slot,
                      head.arg_slot};
    assign m_tuser = head.item_kind;
    assign m_tlast = head.run_end;

endmodule

`default_nettype wire

// ----- design/csi_pp_fifo.sv -----
// ============================================================================
// CSI parser result queue
// Four-word queue that takes up to two result words per cycle and hands out
// one per cycle while pop is high; it reports room whenever two more words fit.
// ============================================================================
`default_nettype none

module csi_pp_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [1:0]          push_count,
    input  wire csi_pp_pkg::result_t push_first,
    input  wire csi_pp_pkg::result_t push_second,
    input  wire logic                pop,
    output csi_pp_pkg::result_t      head,
    output logic                     not_empty,
    output logic                     room_two
);
    import csi_pp_pkg::*;

    result_t    slot_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       do_pop;

    assign do_pop    = pop && (count_reg != 3'd0);
    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 3'd0);
    assign room_two  = (count_reg <= 3'd2);

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
        count_next  = count_reg + {1'b0, push_count} - {2'b00, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming words
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2) begin
            slot_reg[wr_ptr_reg + 2'd1] <= push_second;
        end
    end

endmodule

`default_nettype wire

// ----- design/csi_pp_core.sv -----
// ============================================================================
// CSI parser scan core
// Holds the scan state and combinationally turns one body byte into up to
// two result words.
// ============================================================================
`default_nettype none

module csi_pp_core #(
    parameter int MAX_ARGS    = 16,
    parameter int MAX_SUBARGS = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                take,
    input  wire logic [7:0]          data_byte,
    input  wire logic                end_of_body,
    output logic [1:0]               res_count,
    output csi_pp_pkg::result_t      res_first,
    output csi_pp_pkg::result_t      res_second
);
    import csi_pp_pkg::*;

    localparam int AW = $clog2(MAX_ARGS + 1);
    localparam int SW = $clog2(MAX_SUBARGS + 1);

    typedef struct packed {
        phase_t          phase;
        logic            priv;
        logic [30:0]     acc;
        logic            neg;
        logic            ovf;
        logic [AW-1:0]   argc;
        logic [SW-1:0]   subc;
        logic [7:0]      pend0;
        logic [7:0]      pend1;
        logic [7:0]      capt;
        logic            is_sub;
        logic [1:0]      nchars;
    } pstate_t;

    typedef struct packed {
        pstate_t    ps;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } work_t;

    pstate_t ps_reg;
    pstate_t ps_next;
    work_t   step;

    function automatic logic [3:0] slot4(logic [AW-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[3:0];
    endfunction

    function automatic logic [4:0] tot5(logic [AW-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[4:0];
    endfunction

    function automatic logic [1:0] sub2(logic [SW-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[1:0];
    endfunction

    // Append one result word, dropping any beyond two
    function automatic work_t put(work_t w, logic [1:0] kind, logic [3:0] aslot,
                                  logic [1:0] sslot, logic [31:0] val,
                                  logic [7:0] fin, logic [7:0] sec, logic [4:0] tot);
        result_t r;
        r.item_kind    = kind;
        r.arg_slot     = aslot;
        r.sub_slot     = sslot;
        r.number_value = val;
        r.private_mark = w.ps.priv;
        r.final_char   = fin;
        r.second_char  = sec;
        r.arg_total    = tot;
        r.run_end      = 1'b0;
        if (w.n == 2'd0) begin
            w.r0 = r;
            w.n  = 2'd1;
        end else if (w.n == 2'd1) begin
            w.r1 = r;
            w.n  = 2'd2;
        end
        return w;
    endfunction

    function automatic work_t summary(work_t w, logic [7:0] fin, logic [7:0] sec);
        w = put(w, KIND_SUMMARY, 4'd0, 2'd0, 32'd0, fin, sec, tot5(w.ps.argc));
        w.ps.phase = PH_SKIP;
        return w;
    endfunction

    function automatic work_t begin_field(work_t w, logic sub);
        w.ps.is_sub = sub;
        w.ps.phase  = PH_LEAD;
        w.ps.nchars = 2'd0;
        w.ps.acc    = '0;
        w.ps.neg    = 1'b0;
        w.ps.ovf    = 1'b0;
        w.ps.pend0  = 8'd0;
        w.ps.pend1  = 8'd0;
        return w;
    endfunction

    function automatic work_t emit_value(work_t w);
        logic [31:0] v;
        if (w.ps.ovf) begin
            v = '1;
        end else if (w.ps.neg) begin
            v = 32'd0 - {1'b0, w.ps.acc};
        end else begin
            v = {1'b0, w.ps.acc};
        end
        if (w.ps.is_sub) begin
            w = put(w, KIND_SUB, slot4(w.ps.argc - AW'(1)), sub2(w.ps.subc), v,
                    8'd0, 8'd0, 5'd0);
            w.ps.subc = w.ps.subc + SW'(1);
        end else begin
            w = put(w, KIND_ARG, slot4(w.ps.argc), 2'd0, v, 8'd0, 8'd0, 5'd0);
            w.ps.argc = w.ps.argc + AW'(1);
            w.ps.subc = '0;
        end
        return w;
    endfunction

    // Decide what follows the byte that ended a field
    function automatic work_t terminate(work_t w, logic [7:0] t);
        if (t == CH_COLON && int'(w.ps.subc) < MAX_SUBARGS) begin
            w.ps.phase = PH_COLON;
        end else if (t == CH_SEMI && int'(w.ps.argc) < MAX_ARGS) begin
            w = begin_field(w, 1'b0);
        end else begin
            w.ps.capt  = t;
            w.ps.phase = PH_WAIT;
        end
        return w;
    endfunction

    // No digits: report zero, then end at b or stop at its first byte
    function automatic work_t fail(work_t w, logic [7:0] b);
        w = emit_value(w);
        if (w.ps.nchars == 2'd0) begin
            w = terminate(w, b);
        end else begin
            w = summary(w, w.ps.pend0, (w.ps.nchars == 2'd2) ? w.ps.pend1 : b);
        end
        return w;
    endfunction

    function automatic work_t note(work_t w, logic [7:0] b);
        if (w.ps.nchars == 2'd0) begin
            w.ps.pend0  = b;
            w.ps.nchars = 2'd1;
        end else if (w.ps.nchars == 2'd1) begin
            w.ps.pend1  = b;
            w.ps.nchars = 2'd2;
        end
        return w;
    endfunction

    function automatic work_t field_byte(work_t w, logic [7:0] b);
        logic        digit;
        logic        space;
        logic [7:0]  diff;
        logic [3:0]  d;
        logic [34:0] nx;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        diff  = b - CH_ZERO;
        d     = diff[3:0];
        nx    = 35'({w.ps.acc, 3'b000}) + 35'({w.ps.acc, 1'b0}) + 35'(d);
        if (w.ps.phase == PH_LEAD && space) begin
            w = note(w, b);
        end else if (w.ps.phase == PH_LEAD && (b == CH_PLUS || b == CH_MINUS)) begin
            w.ps.neg   = (b == CH_MINUS);
            w          = note(w, b);
            w.ps.phase = PH_SIGN;
        end else if (w.ps.phase == PH_LEAD || w.ps.phase == PH_SIGN) begin
            if (digit) begin
                w.ps.acc   = 31'(d);
                w.ps.phase = PH_DIGIT;
            end else begin
                w = fail(w, b);
            end
        end else if (digit) begin
            if (!w.ps.ovf) begin
                if (nx > 35'h0_7FFF_FFFF) begin
                    w.ps.ovf = 1'b1;
                end else begin
                    w.ps.acc = nx[30:0];
                end
            end
        end else begin
            w = emit_value(w);
            w = terminate(w, b);
        end
        return w;
    endfunction

    // Evaluate one byte against the current scan state
    always_comb begin
        step    = '0;
        step.ps = ps_reg;
        unique case (ps_reg.phase)
            PH_START: begin
                step.ps.priv = 1'b0;
                step.ps.argc = '0;
                step.ps.subc = '0;
                step         = begin_field(step, 1'b0);
                if (data_byte == CH_QMARK) begin
                    step.ps.priv = 1'b1;
                end else begin
                    step = field_byte(step, data_byte);
                end
            end
            PH_LEAD, PH_SIGN, PH_DIGIT: begin
                step = field_byte(step, data_byte);
            end
            PH_COLON: begin
                if (data_byte != CH_COLON) begin
                    step = begin_field(step, 1'b1);
                    step = field_byte(step, data_byte);
                end
            end
            PH_WAIT: begin
                step = summary(step, step.ps.capt, data_byte);
            end
            default: begin
            end
        endcase

        // Close out the scan at the end of the body
        if (end_of_body) begin
            unique case (step.ps.phase)
                PH_LEAD: begin
                    if (step.ps.nchars == 2'd0) begin
                        step = summary(step, 8'd0, 8'd0);
                    end else begin
                        step = fail(step, 8'd0);
                    end
                end
                PH_SIGN: begin
                    step = fail(step, 8'd0);
                end
                PH_DIGIT: begin
                    step = emit_value(step);
                    step = summary(step, 8'd0, 8'd0);
                end
                PH_COLON: begin
                    step = summary(step, 8'd0, 8'd0);
                end
                PH_WAIT: begin
                    step = summary(step, step.ps.capt, 8'd0);
                end
                default: begin
                end
            endcase
            step.ps.phase = PH_START;
        end
    end

    // Next state: advance only on an accepted byte
    always_comb begin
        ps_next = take ? step.ps : ps_reg;
    end

    // Outputs: mark the last word of this byte
    always_comb begin
        res_count  = take ? step.n : 2'd0;
        res_first  = step.r0;
        res_second = step.r1;
        res_first.run_end  = (step.n == 2'd1);
        res_second.run_end = (step.n == 2'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg <= '{phase: PH_START, default: '0};
        end else begin
            ps_reg <= ps_next;
        end
    end

endmodule

`default_nettype wire
